### rtl/tfn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal unit
// widths of the vertex store and the arithmetic, controller states,
// datapath operations and the command and status groups
// ----------------------------------------------------------------------------
package tfn_pkg;

   // vertex store
   localparam int VERTEX_DEPTH = 4096;
   localparam int COORD_WIDTH  = 16;
   localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
   localparam int VERTEX_W     = 3 * COORD_WIDTH;

   // port fields
   localparam int INDEX_W  = 12;
   localparam int POS_W    = 16;
   localparam int NORMAL_W = 16;

   // arithmetic widths
   localparam int EDGE_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = (CROSS_W > 32) ? CROSS_W : 32;
   localparam int SQ_OP_W     = 31;
   localparam int SQ_PROD_W   = 2 * SQ_OP_W;
   localparam int SQ_W        = 64;
   localparam int ROOT_W      = 32;
   localparam int FRAC_W      = 15;
   localparam int REM_W       = 48;
   localparam int QUO_W       = 16;
   localparam int NORM_HI_BIT = 31;
   localparam int NORM_LO_BIT = 30;
   localparam int COARSE_BIT  = 23;
   localparam int COARSE_SH   = 8;

   localparam logic [SQ_W-1:0] ROOT_START = SQ_W'(1) << (SQ_W - 2);

   // sequencing
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] CROSS_LAST = STEP_W'(5);
   localparam logic [STEP_W-1:0] SQ_LAST    = STEP_W'(2);
   localparam logic [STEP_W-1:0] ROOT_LAST  = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(QUO_W - 1);

   typedef enum logic [1:0] {
      COMP_X,
      COMP_Y,
      COMP_Z
   } comp_type;

   typedef enum logic {
      OP_WRITE_VERTEX = 1'b0,
      OP_TRIANGLE     = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_CAP_C,
      ST_CROSS,
      ST_MAG,
      ST_NORM,
      ST_SQ,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_WRITE,
      DP_LATCH,
      DP_RD_A,
      DP_RD_B,
      DP_RD_C,
      DP_CAP_C,
      DP_CROSS,
      DP_MAG,
      DP_NORM,
      DP_SQ,
      DP_ROOT_LOAD,
      DP_ROOT,
      DP_DIV_LOAD,
      DP_DIV_STEP,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [STEP_W-1:0]  step;
      comp_type           comp;
   } cmd_type;

   typedef struct packed {
      logic is_zero;
      logic is_normed;
   } status_type;

endpackage
`default_nettype wire

### rtl/tfn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_if: request and response channels of the triangle face normal unit
// valid/ready handshake, a beat moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface tfn_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic        [tfn_pkg::INDEX_W-1:0]  vertex_index;
   logic signed [tfn_pkg::POS_W-1:0]    pos_x;
   logic signed [tfn_pkg::POS_W-1:0]    pos_y;
   logic signed [tfn_pkg::POS_W-1:0]    pos_z;
   logic        [tfn_pkg::INDEX_W-1:0]  corner_a;
   logic        [tfn_pkg::INDEX_W-1:0]  corner_b;
   logic        [tfn_pkg::INDEX_W-1:0]  corner_c;

   modport source (
      output valid, opcode, vertex_index, pos_x, pos_y, pos_z,
             corner_a, corner_b, corner_c,
      input  ready
   );
   modport sink (
      input  valid, opcode, vertex_index, pos_x, pos_y, pos_z,
             corner_a, corner_b, corner_c,
      output ready
   );
endinterface

interface tfn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tfn_pkg::NORMAL_W-1:0] normal_x;
   logic signed [tfn_pkg::NORMAL_W-1:0] normal_y;
   logic signed [tfn_pkg::NORMAL_W-1:0] normal_z;
   logic                                degenerate;

   modport source (
      output valid, normal_x, normal_y, normal_z, degenerate,
      input  ready
   );
   modport sink (
      input  valid, normal_x, normal_y, normal_z, degenerate,
      output ready
   );
endinterface
`default_nettype wire

### rtl/tfn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/tfn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_ctrl: sequencer of the triangle face normal unit
// steps the datapath through fetch, cross product, scaling, sum of squares, root and divide
// ----------------------------------------------------------------------------
module tfn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  tfn_pkg::status_type  status,
   output tfn_pkg::cmd_type     cmd
);

   tfn_pkg::state_type                 state_ff, state_in;
   logic [tfn_pkg::STEP_W-1:0]         step_ff, step_in;
   tfn_pkg::comp_type                  comp_ff, comp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfn_pkg::ST_IDLE;
         step_ff      <= '0;
         comp_ff      <= tfn_pkg::COMP_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = tfn_pkg::DP_NOP;
      cmd.step     = step_ff;
      cmd.comp     = comp_ff;
      unique case (state_ff)
         tfn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == tfn_pkg::OP_TRIANGLE) begin
                  cmd.op   = tfn_pkg::DP_LATCH;
                  state_in = tfn_pkg::ST_RD_A;
               end else begin
                  cmd.op = tfn_pkg::DP_WRITE;
               end
            end
         end
         tfn_pkg::ST_RD_A: begin
            cmd.op   = tfn_pkg::DP_RD_A;
            state_in = tfn_pkg::ST_RD_B;
         end
         tfn_pkg::ST_RD_B: begin
            cmd.op   = tfn_pkg::DP_RD_B;
            state_in = tfn_pkg::ST_RD_C;
         end
         tfn_pkg::ST_RD_C: begin
            cmd.op   = tfn_pkg::DP_RD_C;
            state_in = tfn_pkg::ST_CAP_C;
         end
         tfn_pkg::ST_CAP_C: begin
            cmd.op   = tfn_pkg::DP_CAP_C;
            step_in  = '0;
            state_in = tfn_pkg::ST_CROSS;
         end
         tfn_pkg::ST_CROSS: begin
            cmd.op = tfn_pkg::DP_CROSS;
            if (step_ff == tfn_pkg::CROSS_LAST) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_MAG;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_MAG: begin
            cmd.op   = tfn_pkg::DP_MAG;
            state_in = tfn_pkg::ST_NORM;
         end
         tfn_pkg::ST_NORM: begin
            priority if (status.is_zero) begin
               state_in = tfn_pkg::ST_DONE;
            end else if (status.is_normed) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_SQ;
            end else begin
               cmd.op = tfn_pkg::DP_NORM;
            end
         end
         tfn_pkg::ST_SQ: begin
            cmd.op = tfn_pkg::DP_SQ;
            if (step_ff == tfn_pkg::SQ_LAST) begin
               step_in  = '0;
               state_in = tfn_pkg::ST_ROOT_LOAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_ROOT_LOAD: begin
            cmd.op   = tfn_pkg::DP_ROOT_LOAD;
            step_in  = '0;
            state_in = tfn_pkg::ST_ROOT;
         end
         tfn_pkg::ST_ROOT: begin
            cmd.op = tfn_pkg::DP_ROOT;
            if (step_ff == tfn_pkg::ROOT_LAST) begin
               step_in  = '0;
               comp_in  = tfn_pkg::COMP_X;
               state_in = tfn_pkg::ST_DIV_LOAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_DIV_LOAD: begin
            cmd.op   = tfn_pkg::DP_DIV_LOAD;
            step_in  = '0;
            state_in = tfn_pkg::ST_DIV_STEP;
         end
         tfn_pkg::ST_DIV_STEP: begin
            cmd.op = tfn_pkg::DP_DIV_STEP;
            if (step_ff == tfn_pkg::DIV_LAST) begin
               step_in = '0;
               if (comp_ff == tfn_pkg::COMP_Z) begin
                  state_in = tfn_pkg::ST_DONE;
               end else begin
                  comp_in  = (comp_ff == tfn_pkg::COMP_X) ? tfn_pkg::COMP_Y
                                                          : tfn_pkg::COMP_Z;
                  state_in = tfn_pkg::ST_DIV_LOAD;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         tfn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = tfn_pkg::DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = tfn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfn_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/tfn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_dp: datapath of the triangle face normal unit
// vertex memory, edge and cross product, scaling, sum of squares, integer root, divider
// ----------------------------------------------------------------------------
module tfn_dp (
   input  logic                                clock,
   input  tfn_pkg::cmd_type                    cmd,
   output tfn_pkg::status_type                 status,
   input  logic        [tfn_pkg::INDEX_W-1:0]  vertex_index,
   input  logic signed [tfn_pkg::POS_W-1:0]    pos_x,
   input  logic signed [tfn_pkg::POS_W-1:0]    pos_y,
   input  logic signed [tfn_pkg::POS_W-1:0]    pos_z,
   input  logic        [tfn_pkg::INDEX_W-1:0]  corner_a,
   input  logic        [tfn_pkg::INDEX_W-1:0]  corner_b,
   input  logic        [tfn_pkg::INDEX_W-1:0]  corner_c,
   output logic signed [tfn_pkg::NORMAL_W-1:0] normal_x,
   output logic signed [tfn_pkg::NORMAL_W-1:0] normal_y,
   output logic signed [tfn_pkg::NORMAL_W-1:0] normal_z,
   output logic                                degenerate
);

   localparam int CW = tfn_pkg::COORD_WIDTH;

   // vertex memory
   logic                             wr_en;
   logic [tfn_pkg::ADDR_W-1:0]       wr_addr;
   logic [tfn_pkg::VERTEX_W-1:0]     wr_data;
   logic                             rd_en;
   logic [tfn_pkg::ADDR_W-1:0]       rd_addr;
   logic [tfn_pkg::VERTEX_W-1:0]     rd_data;

   // corner slots
   logic [tfn_pkg::ADDR_W-1:0]       ca_ff, cb_ff, cc_ff;
   logic                             a_ok_ff, b_ok_ff, c_ok_ff;
   logic signed [CW-1:0]             ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [CW-1:0]             rx, ry, rz;
   logic                             rd_ok;

   // edges and cross product
   logic signed [tfn_pkg::EDGE_W-1:0]  ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [tfn_pkg::EDGE_W-1:0]  mul_l, mul_r;
   logic signed [tfn_pkg::PROD_W-1:0]  prod;
   logic signed [tfn_pkg::CROSS_W-1:0] prod_ext, n_sel;
   logic signed [tfn_pkg::CROSS_W-1:0] nx_ff, ny_ff, nz_ff;

   // magnitudes and scaling
   logic [tfn_pkg::MAG_W-1:0]        mx_ff, my_ff, mz_ff, mmax, m_sel;
   logic                             too_big, coarse;

   // sum of squares and root
   logic [tfn_pkg::SQ_OP_W-1:0]      sq_op;
   logic [tfn_pkg::SQ_PROD_W-1:0]    sq;
   logic [tfn_pkg::SQ_W-1:0]         acc_ff, rv_ff, res_ff, bit_ff, trial;

   // divider
   logic [tfn_pkg::REM_W-1:0]        rem_ff, den_ff;
   logic [tfn_pkg::QUO_W-1:0]        quo_ff, quo_next, quo_signed;
   logic                             fits, neg_sel;
   logic [tfn_pkg::ROOT_W-1:0]       len;
   logic signed [tfn_pkg::NORMAL_W-1:0] qx_ff, qy_ff, qz_ff;

   // output register
   logic signed [tfn_pkg::NORMAL_W-1:0] normal_x_ff, normal_y_ff, normal_z_ff;
   logic                                degenerate_ff;

   assign wr_en   = (cmd.op == tfn_pkg::DP_WRITE) &&
                    (32'(vertex_index) < tfn_pkg::VERTEX_DEPTH);
   assign wr_addr = tfn_pkg::ADDR_W'(vertex_index);
   assign wr_data = {CW'($unsigned(pos_z)), CW'($unsigned(pos_y)),
                     CW'($unsigned(pos_x))};

   assign rd_en = (cmd.op == tfn_pkg::DP_RD_A) || (cmd.op == tfn_pkg::DP_RD_B) ||
                  (cmd.op == tfn_pkg::DP_RD_C);

   always_comb begin
      priority case (cmd.op)
         tfn_pkg::DP_RD_A: rd_addr = ca_ff;
         tfn_pkg::DP_RD_B: rd_addr = cb_ff;
         default:          rd_addr = cc_ff;
      endcase
   end

   tfn_ram #(
      .WIDTH (tfn_pkg::VERTEX_W),
      .DEPTH (tfn_pkg::VERTEX_DEPTH)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the read word belongs to the corner fetched in the cycle before
   always_comb begin
      priority case (cmd.op)
         tfn_pkg::DP_RD_B: rd_ok = a_ok_ff;
         tfn_pkg::DP_RD_C: rd_ok = b_ok_ff;
         default:          rd_ok = c_ok_ff;
      endcase
      rx = rd_ok ? $signed(rd_data[CW-1:0])      : '0;
      ry = rd_ok ? $signed(rd_data[2*CW-1:CW])   : '0;
      rz = rd_ok ? $signed(rd_data[3*CW-1:2*CW]) : '0;
   end

   // cross product terms, one product per step
   always_comb begin
      unique case (cmd.step[2:0])
         3'd0:    begin mul_l = uy_ff; mul_r = vz_ff; end
         3'd1:    begin mul_l = uz_ff; mul_r = vy_ff; end
         3'd2:    begin mul_l = uz_ff; mul_r = vx_ff; end
         3'd3:    begin mul_l = ux_ff; mul_r = vz_ff; end
         3'd4:    begin mul_l = ux_ff; mul_r = vy_ff; end
         default: begin mul_l = uy_ff; mul_r = vx_ff; end
      endcase
   end
   assign prod     = tfn_pkg::PROD_W'(mul_l) * tfn_pkg::PROD_W'(mul_r);
   assign prod_ext = tfn_pkg::CROSS_W'(prod);

   // largest magnitude and scaling decisions
   always_comb begin
      mmax = mx_ff;
      if (my_ff > mmax) mmax = my_ff;
      if (mz_ff > mmax) mmax = mz_ff;
   end
   assign too_big          = |mmax[tfn_pkg::MAG_W-1:tfn_pkg::NORM_HI_BIT];
   assign coarse           = ~|mmax[tfn_pkg::MAG_W-1:tfn_pkg::COARSE_BIT];
   assign status.is_zero   = (mmax == '0);
   assign status.is_normed = !too_big && mmax[tfn_pkg::NORM_LO_BIT];

   // component picked for dividing, with its sign
   always_comb begin
      unique case (cmd.comp)
         tfn_pkg::COMP_X: begin m_sel = mx_ff; n_sel = nx_ff; end
         tfn_pkg::COMP_Y: begin m_sel = my_ff; n_sel = ny_ff; end
         default:         begin m_sel = mz_ff; n_sel = nz_ff; end
      endcase
   end

   always_comb begin
      unique case (cmd.step[1:0])
         2'd0:    sq_op = mx_ff[tfn_pkg::SQ_OP_W-1:0];
         2'd1:    sq_op = my_ff[tfn_pkg::SQ_OP_W-1:0];
         default: sq_op = mz_ff[tfn_pkg::SQ_OP_W-1:0];
      endcase
   end
   assign sq = tfn_pkg::SQ_PROD_W'(sq_op) * tfn_pkg::SQ_PROD_W'(sq_op);

   assign trial = res_ff + bit_ff;
   assign len   = res_ff[tfn_pkg::ROOT_W-1:0];

   assign fits       = rem_ff >= den_ff;
   assign quo_next   = {quo_ff[tfn_pkg::QUO_W-2:0], fits};
   assign neg_sel    = n_sel[tfn_pkg::CROSS_W-1];
   assign quo_signed = neg_sel ? (~quo_next + 1'b1) : quo_next;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         tfn_pkg::DP_LATCH: begin
            ca_ff   <= tfn_pkg::ADDR_W'(corner_a);
            cb_ff   <= tfn_pkg::ADDR_W'(corner_b);
            cc_ff   <= tfn_pkg::ADDR_W'(corner_c);
            a_ok_ff <= 32'(corner_a) < tfn_pkg::VERTEX_DEPTH;
            b_ok_ff <= 32'(corner_b) < tfn_pkg::VERTEX_DEPTH;
            c_ok_ff <= 32'(corner_c) < tfn_pkg::VERTEX_DEPTH;
         end
         tfn_pkg::DP_RD_B: begin
            ax_ff <= rx;
            ay_ff <= ry;
            az_ff <= rz;
         end
         tfn_pkg::DP_RD_C: begin
            bx_ff <= rx;
            by_ff <= ry;
            bz_ff <= rz;
         end
         tfn_pkg::DP_CAP_C: begin
            ux_ff <= tfn_pkg::EDGE_W'(bx_ff) - tfn_pkg::EDGE_W'(ax_ff);
            uy_ff <= tfn_pkg::EDGE_W'(by_ff) - tfn_pkg::EDGE_W'(ay_ff);
            uz_ff <= tfn_pkg::EDGE_W'(bz_ff) - tfn_pkg::EDGE_W'(az_ff);
            vx_ff <= tfn_pkg::EDGE_W'(rx) - tfn_pkg::EDGE_W'(ax_ff);
            vy_ff <= tfn_pkg::EDGE_W'(ry) - tfn_pkg::EDGE_W'(ay_ff);
            vz_ff <= tfn_pkg::EDGE_W'(rz) - tfn_pkg::EDGE_W'(az_ff);
         end
         tfn_pkg::DP_CROSS: begin
            // even step loads the first term, odd step subtracts the second
            unique case (cmd.step[2:1])
               2'd0:    nx_ff <= cmd.step[0] ? nx_ff - prod_ext : prod_ext;
               2'd1:    ny_ff <= cmd.step[0] ? ny_ff - prod_ext : prod_ext;
               default: nz_ff <= cmd.step[0] ? nz_ff - prod_ext : prod_ext;
            endcase
         end
         tfn_pkg::DP_MAG: begin
            mx_ff <= tfn_pkg::MAG_W'($unsigned(nx_ff[tfn_pkg::CROSS_W-1] ? -nx_ff : nx_ff));
            my_ff <= tfn_pkg::MAG_W'($unsigned(ny_ff[tfn_pkg::CROSS_W-1] ? -ny_ff : ny_ff));
            mz_ff <= tfn_pkg::MAG_W'($unsigned(nz_ff[tfn_pkg::CROSS_W-1] ? -nz_ff : nz_ff));
         end
         tfn_pkg::DP_NORM: begin
            priority if (too_big) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
               mz_ff <= mz_ff >> 1;
            end else if (coarse) begin
               mx_ff <= mx_ff << tfn_pkg::COARSE_SH;
               my_ff <= my_ff << tfn_pkg::COARSE_SH;
               mz_ff <= mz_ff << tfn_pkg::COARSE_SH;
            end else begin
               mx_ff <= mx_ff << 1;
               my_ff <= my_ff << 1;
               mz_ff <= mz_ff << 1;
            end
         end
         tfn_pkg::DP_SQ: begin
            acc_ff <= (cmd.step == '0) ? tfn_pkg::SQ_W'(sq)
                                       : acc_ff + tfn_pkg::SQ_W'(sq);
         end
         tfn_pkg::DP_ROOT_LOAD: begin
            rv_ff  <= acc_ff;
            res_ff <= '0;
            bit_ff <= tfn_pkg::ROOT_START;
         end
         tfn_pkg::DP_ROOT: begin
            if (rv_ff >= trial) begin
               rv_ff  <= rv_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         tfn_pkg::DP_DIV_LOAD: begin
            // (m * 2^15 + len) / (2 * len), rounded half away from zero
            rem_ff <= (tfn_pkg::REM_W'(m_sel[tfn_pkg::SQ_OP_W-1:0]) << tfn_pkg::FRAC_W)
                      + tfn_pkg::REM_W'(len);
            den_ff <= tfn_pkg::REM_W'({len, 1'b0}) << (tfn_pkg::QUO_W - 1);
            quo_ff <= '0;
         end
         tfn_pkg::DP_DIV_STEP: begin
            if (fits) begin
               rem_ff <= rem_ff - den_ff;
            end
            den_ff <= den_ff >> 1;
            quo_ff <= quo_next;
            unique case (cmd.comp)
               tfn_pkg::COMP_X: qx_ff <= $signed(quo_signed);
               tfn_pkg::COMP_Y: qy_ff <= $signed(quo_signed);
               default:         qz_ff <= $signed(quo_signed);
            endcase
         end
         tfn_pkg::DP_OUT: begin
            normal_x_ff   <= status.is_zero ? '0 : qx_ff;
            normal_y_ff   <= status.is_zero ? '0 : qy_ff;
            normal_z_ff   <= status.is_zero ? '0 : qz_ff;
            degenerate_ff <= status.is_zero;
         end
         default: begin
         end
      endcase
   end

   assign normal_x   = normal_x_ff;
   assign normal_y   = normal_y_ff;
   assign normal_z   = normal_z_ff;
   assign degenerate = degenerate_ff;

endmodule
`default_nettype wire

### rtl/triangle_face_normal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normals of mesh triangles
// sequence: a vertex write takes one beat; a triangle raises its result beat
//   after fetch, cross product, scaling, sum of squares, root and three divides,
//   a degenerate one once the magnitudes show zero, plus any wait on rsp ready
// throughput: vertex writes one per cycle while the sequencer is idle;
//   triangles one at a time, none taken until the last result is out, the
//   rate set by the 32-step integer root and three restoring divisions
// reset: synchronous, clears the sequencer and response valid; the vertex
//   memory is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
module triangle_face_normal (
   input  logic       clock,
   input  logic       reset,
   tfn_req_if.sink    req_bus,
   tfn_rsp_if.source  rsp_bus
);

   // command and status between the sequencer and the datapath
   tfn_pkg::cmd_type    cmd;
   tfn_pkg::status_type status;

   // sequencer: accepts beats only when idle; a waiting response beat, in its
   // own output register, does not hold that off; the next result waits on it
   tfn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: vertex memory, edges, cross product one term per cycle,
   // power-of-two scaling to [2^30, 2^31), sum of squares, bitwise root,
   // then one divide per component with round half away from zero
   tfn_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .vertex_index (req_bus.vertex_index),
      .pos_x        (req_bus.pos_x),
      .pos_y        (req_bus.pos_y),
      .pos_z        (req_bus.pos_z),
      .corner_a     (req_bus.corner_a),
      .corner_b     (req_bus.corner_b),
      .corner_c     (req_bus.corner_c),
      .normal_x     (rsp_bus.normal_x),
      .normal_y     (rsp_bus.normal_y),
      .normal_z     (rsp_bus.normal_z),
      .degenerate   (rsp_bus.degenerate)
   );

endmodule
`default_nettype wire

### tb/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker: face normal predictor and response comparison
// watches both channels, keeps a shadow vertex store, predicts the normal of
// every accepted triangle beat and compares each response beat against it
// ----------------------------------------------------------------------------
module tfn_checker (
   input  logic      clock,
   input  logic      reset,
   tfn_req_if        req_mon,
   tfn_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   typedef struct packed {
      logic signed [tfn_pkg::NORMAL_W-1:0] nx;
      logic signed [tfn_pkg::NORMAL_W-1:0] ny;
      logic signed [tfn_pkg::NORMAL_W-1:0] nz;
      logic                                degen;
   } normal_type;

   logic signed [tfn_pkg::COORD_WIDTH-1:0] shadow_x [tfn_pkg::VERTEX_DEPTH];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] shadow_y [tfn_pkg::VERTEX_DEPTH];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] shadow_z [tfn_pkg::VERTEX_DEPTH];
   normal_type normal_q[$];

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] scale_comp(input logic [63:0] mag, input logic neg,
                                              input logic [63:0] len);
      logic [63:0] q;
      q = ((mag << 15) + len) / (len << 1);
      if (neg) q = -q;
      return q[15:0];
   endfunction

   function automatic normal_type face_normal(input logic [11:0] ia, input logic [11:0] ib,
                                              input logic [11:0] ic);
      longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
      logic [63:0] mx, my, mz, mmax, len;
      normal_type r;
      ux = shadow_x[ib] - shadow_x[ia]; uy = shadow_y[ib] - shadow_y[ia];
      uz = shadow_z[ib] - shadow_z[ia];
      vx = shadow_x[ic] - shadow_x[ia]; vy = shadow_y[ic] - shadow_y[ia];
      vz = shadow_z[ic] - shadow_z[ia];
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      mx = cx < 0 ? -cx : cx;
      my = cy < 0 ? -cy : cy;
      mz = cz < 0 ? -cz : cz;
      mmax = mx;
      if (my > mmax) mmax = my;
      if (mz > mmax) mmax = mz;
      if (mmax == 0) begin
         r = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
         return r;
      end
      while (mmax >= (64'd1 << 31)) begin
         mx >>= 1; my >>= 1; mz >>= 1; mmax >>= 1;
      end
      while (mmax < (64'd1 << 30)) begin
         mx <<= 1; my <<= 1; mz <<= 1; mmax <<= 1;
      end
      len = int_root(mx * mx + my * my + mz * mz);
      r.nx = scale_comp(mx, cx < 0, len);
      r.ny = scale_comp(my, cy < 0, len);
      r.nz = scale_comp(mz, cz < 0, len);
      r.degen = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      normal_type want, got;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         normal_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.opcode == tfn_pkg::OP_WRITE_VERTEX) begin
               shadow_x[req_mon.vertex_index] = req_mon.pos_x;
               shadow_y[req_mon.vertex_index] = req_mon.pos_y;
               shadow_z[req_mon.vertex_index] = req_mon.pos_z;
            end else begin
               normal_q.push_back(face_normal(req_mon.corner_a, req_mon.corner_b,
                                              req_mon.corner_c));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{nx: rsp_mon.normal_x, ny: rsp_mon.normal_y, nz: rsp_mon.normal_z,
                    degen: rsp_mon.degenerate};
            if (normal_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = normal_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("normal mismatch: want %0d %0d %0d d%0b got %0d %0d %0d d%0b",
                              want.nx, want.ny, want.nz, want.degen,
                              got.nx, got.ny, got.nz, got.degen);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= normal_q.size();
      end
   end
endmodule

### tb/triangle_face_normal_tb.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_tb: stimulus and verdict for the face normal unit
// loads vertices, sends directed and random triangles over random idling on
// both channels; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   stall_cycles;
   bit   quiet;          // no idling stretch
   bit   written [tfn_pkg::VERTEX_DEPTH];
   int   written_list[$];

   tfn_req_if req_bus ();
   tfn_rsp_if rsp_bus ();

   triangle_face_normal dut (.clock(clock), .reset(reset), .req_bus(req_bus),
                             .rsp_bus(rsp_bus));
   tfn_checker u_checker (.clock(clock), .reset(reset), .req_mon(req_bus),
                          .rsp_mon(rsp_bus), .fail_count(fail_count),
                          .pending_count(pending_count));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side back-pressure, ready low at random about 19 percent of the time
   always @(posedge clock)
      rsp_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one beat: random idle cycles first, then hold valid until accepted
   task automatic send_beat(input logic op, input logic [11:0] vi,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz, input logic [11:0] ca,
                            input logic [11:0] cb, input logic [11:0] cc);
      while (!quiet && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op; req_bus.vertex_index <= vi;
      req_bus.pos_x <= px; req_bus.pos_y <= py; req_bus.pos_z <= pz;
      req_bus.corner_a <= ca; req_bus.corner_b <= cb; req_bus.corner_c <= cc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == tfn_pkg::OP_WRITE_VERTEX && !written[vi]) begin
         written[vi] = 1;
         written_list.push_back(vi);
      end
   endtask

   task automatic put_vertex(input logic [11:0] vi, input logic [15:0] px,
                             input logic [15:0] py, input logic [15:0] pz);
      // corners random: they are ignored on a vertex write
      send_beat(tfn_pkg::OP_WRITE_VERTEX, vi, px, py, pz, 12'($urandom), 12'($urandom),
                12'($urandom));
   endtask

   task automatic put_tri(input logic [11:0] ca, input logic [11:0] cb,
                          input logic [11:0] cc);
      // index and position fields are don't-care here
      send_beat(tfn_pkg::OP_TRIANGLE, 12'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), ca, cb, cc);
   endtask

   function automatic logic [11:0] any_written();
      return 12'(written_list[$urandom_range(written_list.size() - 1)]);
   endfunction

   function automatic logic [15:0] rand_coord();
      unique case ($urandom_range(3))
         0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1: return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int n;
      logic [11:0] a, b, c;
      req_bus.valid = 0; req_bus.opcode = 0; req_bus.vertex_index = 0;
      req_bus.pos_x = 0; req_bus.pos_y = 0; req_bus.pos_z = 0;
      req_bus.corner_a = 0; req_bus.corner_b = 0; req_bus.corner_c = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: coordinate extremes, corner slots at both ends
      put_vertex(12'd0, 16'h0000, 16'h0000, 16'h0000);
      put_vertex(12'd4095, 16'h7fff, 16'h0000, 16'h0000);
      put_vertex(12'd1, 16'h0000, 16'h7fff, 16'h0000);
      put_vertex(12'd2, 16'h8000, 16'h8000, 16'h8000);
      put_vertex(12'd3, 16'h7fff, 16'h7fff, 16'h7fff);
      put_vertex(12'd4, 16'h8000, 16'h7fff, 16'h0001);
      put_vertex(12'd5, 16'hffff, 16'hffff, 16'hffff);
      put_vertex(12'd6, 16'h0100, 16'h0200, 16'h0300);
      put_tri(12'd0, 12'd4095, 12'd1);       // axis aligned
      put_tri(12'd0, 12'd1, 12'd4095);       // reversed winding
      put_tri(12'd2, 12'd3, 12'd4);          // huge cross product
      put_tri(12'd4, 12'd2, 12'd3);
      put_tri(12'd0, 12'd5, 12'd4095);       // tiny edge
      put_tri(12'd7 - 12'd1, 12'd6, 12'd6);  // degenerate, repeated corner
      put_tri(12'd5, 12'd5, 12'd5);          // degenerate, all same
      put_tri(12'd0, 12'd5, 12'd3);          // degenerate, collinear
      put_tri(12'd0, 12'd6, 12'd3);

      // random: mostly triangles over a growing written set
      for (n = 0; n < 650; n++) begin
         quiet = (n >= 250 && n < 350);
         if (n == 400) begin
            // sender hold-off until the pipe drains
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (written_list.size() < 12 || $urandom_range(99) < 40) begin
            put_vertex(written_list.size() < 200 ? 12'($urandom) : any_written(),
                       rand_coord(), rand_coord(), rand_coord());
         end else begin
            a = any_written(); b = any_written(); c = any_written();
            if ($urandom_range(9) == 0) c = b;   // degenerate now and then
            put_tri(a, b, c);
         end
      end
      quiet = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

### sim.f
rtl/tfn_pkg.sv
rtl/tfn_if.sv
rtl/tfn_ram.sv
rtl/tfn_ctrl.sv
rtl/tfn_dp.sv
rtl/triangle_face_normal.sv
tb/tfn_checker.sv
tb/triangle_face_normal_tb.sv
